### rtl/tpcs_pkg.sv
// Shared types, codes and helpers of the two-point calibration select block.
package tpcs_pkg;

    typedef struct packed {
        logic               func;
        logic [2:0]         gas_index;
        logic               sensor;
        logic [2:0]         point_kind;
        logic               point_present;
        logic signed [31:0] point_value;
        logic signed [31:0] measurement;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] calibrated_value;
        logic [2:0]         cal_kind;
        logic signed [31:0] gain_used;
        logic signed [31:0] offset_used;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_PLAN,
        ST_DIV,
        ST_MUL,
        ST_RND,
        ST_ACC
    } t_state;

    localparam logic       FUNC_WRITE   = 1'b0;
    localparam logic       FUNC_MEASURE = 1'b1;

    localparam logic [2:0] CK_RAW      = 3'd0;
    localparam logic [2:0] CK_ABS      = 3'd1;
    localparam logic [2:0] CK_DIFF_ABS = 3'd2;
    localparam logic [2:0] CK_DIFF     = 3'd3;
    localparam logic [2:0] CK_PART     = 3'd4;
    localparam logic [2:0] CK_ABS_OFF  = 3'd5;

    localparam logic [2:0] PK_REF_ZERO  = 3'd0;
    localparam logic [2:0] PK_REF_SPAN  = 3'd1;
    localparam logic [2:0] PK_SEN_ZERO  = 3'd2;
    localparam logic [2:0] PK_SEN_SPAN  = 3'd3;
    localparam logic [2:0] PK_DIFF_LOW  = 3'd4;
    localparam logic [2:0] PK_DIFF_HIGH = 3'd5;

    localparam int PTS_PER_SENSOR = 6;
    localparam int PTS_PER_GAS    = 12;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/tpcs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module tpcs_div import tpcs_pkg::*; #(
    parameter int DW = 50,
    parameter int RW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [RW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [RW-1:0] r_rem, r_ad;
    logic [RW:0]   rem_sh;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DW-1]};
        ge     = rem_sh >= {1'b0, r_ad};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_ad  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? RW'(rem_sh - {1'b0, r_ad}) : rem_sh[RW-1:0];
            r_dvd <= {r_dvd[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

### rtl/two_point_calibration_select_top.sv
// Top level of the two-point calibration select block.
//
// Keeps six calibration points per gas and per sensor in an internal memory
// (NUM_GASES*12 entries, each a present mark and a 32-bit value). A write
// transfer stores or clears one point and completes in its accept cycle. A
// measure transfer reads the twelve points of its gas (one memory read port
// with a registered read), decides the calibration case in the plan state,
// derives a slope with a serial divider when the case needs one (one quotient
// bit a cycle, then a done strobe), then runs the one shared multiplier twice,
// for the offset and for the calibrated value (multiply, round and accumulate
// states each). A measure item thus keeps the input not ready from its transfer
// until its result is loaded into the output register. The result waits in an
// output register, so the next item is taken while it is still pending. After
// reset a clearing pass marks every point missing before the first item is
// accepted; configuration transfers are taken at any time.
module two_point_calibration_select_top import tpcs_pkg::*; #(
    parameter int NUM_GASES      = 8,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    localparam int DEPTH = NUM_GASES * PTS_PER_GAS;
    localparam int AW    = $clog2(DEPTH);
    localparam int F     = GAIN_FRAC_BITS;
    localparam int RW    = 33;
    localparam int DW    = RW + 1 + F;
    localparam logic signed [31:0] ONE = 32'sd1 <<< F;

    t_state r_state, n_state;

    // point memory
    logic [32:0]   r_mem [DEPTH];
    logic [32:0]   r_rd;
    logic [AW-1:0] rd_addr, wr_addr, r_clr_addr;
    logic [32:0]   wr_data;
    logic          wr_en;

    logic        in_xfer, gas_ok;
    logic [AW-1:0] base;
    logic [3:0]  pt_off;

    logic [15:0] r_eps;
    logic [AW-1:0] r_base;
    logic [3:0]  r_cnt;
    logic        r_cur, r_gas_ok, r_second;
    logic signed [31:0] r_meas;
    logic [32:0] r_pt [PTS_PER_GAS];

    // case plan
    logic               hp [2][6];
    logic signed [31:0] vp [2][6];
    logic               p_div;
    logic signed [32:0] p_num, p_den;
    logic signed [31:0] p_a, p_b;
    logic [2:0]         p_ck;
    logic signed [31:0] r_a, r_b, r_gain, r_off;
    logic [2:0]         r_ck;
    logic               r_neg;

    // divider
    logic          div_start, div_done;
    logic [DW-1:0] div_quot, div_dvd;
    logic [32:0]   anum, aden;
    logic          q_big;
    logic signed [31:0] slope;

    // shared multiplier
    logic signed [31:0] mul_x;
    logic signed [63:0] r_prod, mq;
    logic [63:0]        pmag, pm;
    logic signed [63:0] r_mq;
    logic               out_load;
    logic               r_out_valid;
    t_out_item          r_out;

    function automatic logic near_zero(input logic signed [32:0] d,
                                       input logic [15:0] eps);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : d;
        return m <= {17'd0, eps};
    endfunction

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign gas_ok      = 32'(i_in_data.gas_index) < NUM_GASES;
    assign base        = AW'({i_in_data.gas_index, 3'b000}) + AW'({i_in_data.gas_index, 2'b00});
    assign pt_off      = 4'({i_in_data.sensor, 2'b00}) + 4'({i_in_data.sensor, 1'b0})
                         + 4'(i_in_data.point_kind);

    // Threshold register; take every configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // Memory write port: clearing pass, or a point write.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (r_state == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (in_xfer && i_in_data.func == FUNC_WRITE && gas_ok
                     && i_in_data.point_kind <= PK_DIFF_HIGH) begin
            wr_en   = 1'b1;
            wr_addr = base + AW'(pt_off);
            wr_data = {i_in_data.point_present,
                       i_in_data.point_present ? i_in_data.point_value : 32'sd0};
        end
    end

    assign rd_addr = r_base + AW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Unpack the captured points; drop them all when the gas is out of range.
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 6; k++) begin
                hp[s][k] = r_gas_ok && r_pt[s*PTS_PER_SENSOR + k][32];
                vp[s][k] = r_gas_ok ? r_pt[s*PTS_PER_SENSOR + k][31:0] : 32'sd0;
            end
        end
    end

    // Decision tree. Every case reduces to offset = a - gain*b, with gain
    // either a slope num/den or unit; raw is unit gain with a = b = 0.
    always_comb begin
        logic c, o, cz, cs, oz, os, abs_all, diff_all, done, src, zp;
        c        = r_cur;
        o        = ~r_cur;
        cz       = hp[c][0] && hp[c][2];
        cs       = hp[c][1] && hp[c][3];
        oz       = hp[o][0] && hp[o][2];
        os       = hp[o][1] && hp[o][3];
        abs_all  = hp[c][0] && hp[c][1] && hp[c][2] && hp[c][3];
        diff_all = hp[0][4] && hp[0][5] && hp[1][4] && hp[1][5];
        done     = 1'b0;
        src      = (cz || cs) ? c : o;
        zp       = (cz || cs) ? cz : oz;
        p_div    = 1'b0;
        p_num    = '0;
        p_den    = '0;
        p_a      = '0;
        p_b      = '0;
        p_ck     = CK_RAW;
        if (abs_all) begin
            done  = 1'b1;
            p_den = 33'(vp[c][3]) - 33'(vp[c][2]);
            if (!near_zero(p_den, r_eps)) begin
                p_div = 1'b1;
                p_num = 33'(vp[c][1]) - 33'(vp[c][0]);
                p_a   = vp[c][0];
                p_b   = vp[c][2];
                p_ck  = CK_ABS;
            end
        end else if (diff_all) begin
            p_den = 33'(vp[1][5]) - 33'(vp[1][4]);
            p_num = 33'(vp[0][5]) - 33'(vp[0][4]);
            if (near_zero(p_den, r_eps)) begin
                done = 1'b1;
            end else if (cz || cs || oz || os) begin
                done = 1'b1;
                if (c) begin
                    p_div = 1'b1;
                    p_a   = zp ? vp[src][0] : vp[src][1];
                    p_b   = zp ? vp[src][2] : vp[src][3];
                    p_ck  = CK_DIFF_ABS;
                end
            end else if (!hp[o][0] && !hp[o][1] && !hp[c][0] && !hp[c][1]) begin
                done = 1'b1;
                if (c) begin
                    p_div = 1'b1;
                    p_a   = vp[0][4];
                    p_b   = vp[1][4];
                    p_ck  = CK_DIFF;
                end
            end
        end
        if (!done) begin
            if (cz || cs) begin
                p_a  = cz ? vp[c][0] : vp[c][1];
                p_b  = cz ? vp[c][2] : vp[c][3];
                p_ck = CK_ABS_OFF;
            end else if ((hp[0][4] && hp[1][4]) || (hp[0][5] && hp[1][5])) begin
                if (c) begin
                    p_a  = (hp[0][4] && hp[1][4]) ? vp[0][4] : vp[0][5];
                    p_b  = (hp[0][4] && hp[1][4]) ? vp[1][4] : vp[1][5];
                    p_ck = CK_PART;
                end
            end
        end
    end

    // Divider operands: rounded |num|*2^F / |den|.
    always_comb begin
        anum    = p_num[32] ? 33'(-p_num) : p_num;
        aden    = p_den[32] ? 33'(-p_den) : p_den;
        div_dvd = (DW'(anum) << F) + DW'(aden >> 1);
    end

    assign div_start = (r_state == ST_PLAN) && p_div;

    tpcs_div #(.DW(DW), .RW(RW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (aden),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        q_big = div_quot[DW-1:31] != '0;
        if (r_neg) begin
            slope = q_big ? 32'sh8000_0000 : -$signed(div_quot[31:0]);
        end else begin
            slope = q_big ? 32'sh7fff_ffff : $signed(div_quot[31:0]);
        end
    end

    // Shared multiplier with rounding half away from zero at bit F.
    assign mul_x = r_second ? r_meas : r_b;

    always_comb begin
        pmag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        pm   = (pmag + (64'd1 << (F - 1))) >> F;
        mq   = r_prod[63] ? -$signed(pm) : $signed(pm);
    end

    assign out_load = (r_state == ST_ACC) && r_second && (!r_out_valid || i_out_ready);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_xfer && i_in_data.func == FUNC_MEASURE) n_state = ST_LOAD;
            ST_LOAD:  if (r_cnt == 4'(PTS_PER_GAS)) n_state = ST_PLAN;
            ST_PLAN:  n_state = p_div ? ST_DIV : ST_MUL;
            ST_DIV:   if (div_done) n_state = ST_MUL;
            ST_MUL:   n_state = ST_RND;
            ST_RND:   n_state = ST_ACC;
            ST_ACC: begin
                if (!r_second) begin
                    n_state = ST_MUL;
                end else if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_base   <= base;
                r_cur    <= i_in_data.sensor;
                r_meas   <= i_in_data.measurement;
                r_gas_ok <= gas_ok;
                r_cnt    <= '0;
                r_second <= 1'b0;
            end
            ST_LOAD: begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt != 4'd0) begin
                    r_pt[r_cnt - 4'd1] <= r_rd;
                end
            end
            ST_PLAN: begin
                r_a    <= p_a;
                r_b    <= p_b;
                r_ck   <= p_ck;
                r_neg  <= p_num[32] != p_den[32];
                r_gain <= ONE;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_gain <= slope;
                end
            end
            ST_MUL: r_prod <= r_gain * mul_x;
            ST_RND: r_mq   <= mq;
            ST_ACC: begin
                if (!r_second) begin
                    r_off    <= sat32(66'(r_a) - 66'(r_mq));
                    r_second <= 1'b1;
                end
                if (out_load) begin
                    r_out.calibrated_value <= sat32(66'(r_mq) + 66'(r_off));
                    r_out.cal_kind         <= r_ck;
                    r_out.gain_used        <= r_gain;
                    r_out.offset_used      <= r_off;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### rtl/tpcs_chk.sv
// Port-level checker for the two-point calibration select block, with its bind.
module tpcs_chk import tpcs_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data
);
    localparam logic signed [31:0] ONE = 32'sd1 <<< GAIN_FRAC_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.func == FUNC_MEASURE |=> !o_in_ready)
        else $error("input ready right after a measure transfer");

    a_raw_is_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cal_kind == CK_RAW |->
            o_out_data.gain_used == ONE && o_out_data.offset_used == 32'sd0)
        else $error("raw result with non-unit gain or nonzero offset");

    a_offset_only_unit_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.cal_kind == CK_ABS_OFF || o_out_data.cal_kind == CK_PART)
            |-> o_out_data.gain_used == ONE)
        else $error("offset-only result with non-unit gain");

    a_no_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready && i_in_data.func == FUNC_WRITE
            |=> !o_out_valid)
        else $error("write transfer produced a result");
endmodule

bind two_point_calibration_select_top tpcs_chk #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_chk (.*);

### verif/tpcs_checker.sv
// Checker for the calibration select block: point store model, prediction and compare.
module tpcs_checker import tpcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NUM_GASES = 8;
    localparam int     FRAC      = 16;
    localparam longint UNIT_GAIN = 64'sd1 << FRAC;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    bit          pt_has [NUM_GASES*PTS_PER_GAS];
    longint      pt_val [NUM_GASES*PTS_PER_GAS];
    longint      flat_eps;
    t_out_item   expected_cal[$];

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint gain_mul(longint g, longint x);
        longint p, m;
        p = g * x;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint slope(longint num, longint den);
        longint n, an, ad, q;
        n  = num * UNIT_GAIN;
        an = (n < 0) ? -n : n;
        ad = (den < 0) ? -den : den;
        q  = (an + ad / 2) / ad;
        if (q > S32_MAX + 1) q = S32_MAX + 1;
        return clamp32(((n < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic bit is_flat(longint d);
        return ((d < 0) ? -d : d) <= flat_eps;
    endfunction

    function automatic t_out_item calibrate(t_in_item it);
        bit        h [2][6];
        longint    v [2][6];
        longint    gain, offset, gd, den;
        logic [2:0] ck;
        int        cur, oth, src, a;
        bit        cz, cs, oz, os, abs_all, diff_all, done, zp;
        t_out_item r;
        cur = int'(it.sensor);
        oth = cur ^ 1;
        gain = UNIT_GAIN;
        offset = 0;
        ck = CK_RAW;
        done = 0;
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 6; k++) begin
                a = it.gas_index * PTS_PER_GAS + s * PTS_PER_SENSOR + k;
                h[s][k] = (it.gas_index < NUM_GASES) ? pt_has[a] : 1'b0;
                v[s][k] = (it.gas_index < NUM_GASES) ? pt_val[a] : 0;
            end
        end
        cz = h[cur][0] && h[cur][2];
        cs = h[cur][1] && h[cur][3];
        oz = h[oth][0] && h[oth][2];
        os = h[oth][1] && h[oth][3];
        abs_all  = h[cur][0] && h[cur][1] && h[cur][2] && h[cur][3];
        diff_all = h[0][4] && h[0][5] && h[1][4] && h[1][5];

        if (abs_all) begin
            den = v[cur][3] - v[cur][2];
            done = 1;
            if (!is_flat(den)) begin
                gain = slope(v[cur][1] - v[cur][0], den);
                offset = clamp32(v[cur][0] - gain_mul(gain, v[cur][2]));
                ck = CK_ABS;
            end
        end else if (diff_all) begin
            den = v[1][5] - v[1][4];
            if (is_flat(den)) begin
                done = 1;
            end else begin
                gd = slope(v[0][5] - v[0][4], den);
                if (cz || cs || oz || os) begin
                    src = (cz || cs) ? cur : oth;
                    zp = (src == cur) ? cz : oz;
                    done = 1;
                    if (cur == 1) begin
                        gain = gd;
                        offset = zp ? clamp32(v[src][0] - gain_mul(gd, v[src][2]))
                                    : clamp32(v[src][1] - gain_mul(gd, v[src][3]));
                        ck = CK_DIFF_ABS;
                    end
                end else if (!h[oth][0] && !h[oth][1] && !h[cur][0] && !h[cur][1]) begin
                    done = 1;
                    if (cur == 1) begin
                        gain = gd;
                        offset = clamp32(v[0][4] - gain_mul(gd, v[1][4]));
                        ck = CK_DIFF;
                    end
                end
            end
        end

        // Fall back to offset-only corrections when no slope case decided.
        if (!done) begin
            if (cz || cs) begin
                gain = UNIT_GAIN;
                offset = cz ? clamp32(v[cur][0] - v[cur][2]) : clamp32(v[cur][1] - v[cur][3]);
                ck = CK_ABS_OFF;
            end else if ((h[0][4] && h[1][4]) || (h[0][5] && h[1][5])) begin
                if (cur == 1) begin
                    gain = UNIT_GAIN;
                    offset = (h[0][4] && h[1][4]) ? clamp32(v[0][4] - v[1][4])
                                                  : clamp32(v[0][5] - v[1][5]);
                    ck = CK_PART;
                end
            end
        end

        r.calibrated_value = 32'(clamp32(gain_mul(gain, longint'(it.measurement)) + offset));
        r.cal_kind         = ck;
        r.gain_used        = 32'(gain);
        r.offset_used      = 32'(offset);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        flat_eps = 1;
        foreach (pt_has[i]) begin
            pt_has[i] = 0;
            pt_val[i] = 0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        int        a;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) flat_eps = longint'(i_cfg_data);

            if (i_in_valid && i_in_ready) begin
                if (i_in_data.func == FUNC_MEASURE) begin
                    expected_cal.push_back(calibrate(i_in_data));
                end else if (i_in_data.gas_index < NUM_GASES
                             && i_in_data.point_kind < PTS_PER_SENSOR) begin
                    a = i_in_data.gas_index * PTS_PER_GAS
                        + i_in_data.sensor * PTS_PER_SENSOR + i_in_data.point_kind;
                    pt_has[a] = i_in_data.point_present;
                    pt_val[a] = i_in_data.point_present ? longint'(i_in_data.point_value) : 0;
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_cal.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = expected_cal.pop_front();
                    if (i_out_data.calibrated_value !== want.calibrated_value)
                        report("calibrated_value", i_out_data.calibrated_value,
                               want.calibrated_value);
                    if (i_out_data.cal_kind !== want.cal_kind)
                        report("cal_kind", i_out_data.cal_kind, want.cal_kind);
                    if (i_out_data.gain_used !== want.gain_used)
                        report("gain_used", i_out_data.gain_used, want.gain_used);
                    if (i_out_data.offset_used !== want.offset_used)
                        report("offset_used", i_out_data.offset_used, want.offset_used);
                end
            end
            o_pending = expected_cal.size();
        end
    end

endmodule

### verif/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the calibration select block.
module tb;
    import tpcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;   // cycles without any transfer
    localparam int DRAIN_WAIT  = 120;    // longer than one slope measurement
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 360;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    int fail_count;
    int pending;
    int idle_max;      // upper bound of the random gaps on both sides
    bit hold_request;  // ask the receiver for one long hold-off

    two_point_calibration_select_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    tpcs_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Build one item; unused fields stay at zero.
    function automatic t_in_item point_write(int gas, int sen, logic [2:0] kind, bit present,
                                             int value);
        t_in_item it;
        it = '0;
        it.func          = FUNC_WRITE;
        it.gas_index     = 3'(gas);
        it.sensor        = 1'(sen);
        it.point_kind    = kind;
        it.point_present = present;
        it.point_value   = value;
        return it;
    endfunction

    function automatic t_in_item measure(int gas, int sen, int meas);
        t_in_item it;
        it = '0;
        it.func        = FUNC_MEASURE;
        it.gas_index   = 3'(gas);
        it.sensor      = 1'(sen);
        it.measurement = meas;
        return it;
    endfunction

    // Mostly small values so slopes stay in range; sometimes the full 32 bits.
    function automatic int draw_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return int'($urandom_range(0, 400000)) - 200000;
    endfunction

    // Writes dominate so the store builds up every case of the tree; few gases
    // are used most of the time so points of both sensors meet.
    function automatic t_in_item random_item(int present_pct);
        t_in_item it;
        it = '0;
        it.gas_index     = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(0, 1));
        it.sensor        = 1'($urandom_range(0, 1));
        it.point_kind    = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                           : $urandom_range(0, 5));
        it.point_present = ($urandom_range(0, 99) < present_pct);
        it.point_value   = draw_value();
        it.measurement   = draw_value();
        it.func          = ($urandom_range(0, 9) < 6) ? FUNC_WRITE : FUNC_MEASURE;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send(t_in_item it);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drain, let the block settle, then write the threshold register.
    task automatic set_eps(logic [15:0] eps);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= eps;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int present_pct);
        for (int n = 0; n < PHASE_ITEMS; n++) send(random_item(present_pct));
    endtask

    // Receiver: random hold-offs per result, plus one long hold on request.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Watchdog: end the run when no channel has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        idle_max     = 7;
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with exact zero-slope detection.
        set_eps(16'd0);
        send(measure(0, 0, 32'sh7fff_ffff));          // empty store gives raw
        send(measure(0, 1, 32'sh8000_0000));
        send(point_write(0, 0, PK_REF_ZERO, 1, 0));
        send(point_write(0, 0, PK_REF_SPAN, 1, 100000));
        send(point_write(0, 0, PK_SEN_ZERO, 1, 10));
        send(point_write(0, 0, PK_SEN_SPAN, 1, 50010));
        send(point_write(0, 0, 3'd6, 1, -1));         // out-of-range kinds are dropped
        send(point_write(0, 0, 3'd7, 1, -1));
        send(measure(0, 0, 25000));                    // full absolute
        send(point_write(0, 0, PK_SEN_SPAN, 1, 10));  // flat span: raw
        send(measure(0, 0, 32'sh7fff_ffff));
        send(point_write(0, 0, PK_REF_SPAN, 0, 0));   // clear: zero-pair offset only
        send(measure(0, 0, -77));
        send(point_write(1, 0, PK_DIFF_LOW, 1, 1000));
        send(point_write(1, 0, PK_DIFF_HIGH, 1, 201000));
        send(point_write(1, 1, PK_DIFF_LOW, 1, 0));
        send(point_write(1, 1, PK_DIFF_HIGH, 1, 100000));
        send(measure(1, 1, 5000));                     // differential only
        send(measure(1, 0, 5000));                     // decided, but reference stays raw
        send(point_write(1, 1, PK_REF_ZERO, 1, 5));
        send(point_write(1, 1, PK_SEN_ZERO, 1, 3));
        send(measure(1, 1, -5000));                    // differential with absolute offset
        send(point_write(2, 0, PK_DIFF_HIGH, 1, 32'sh7fff_ffff));
        send(point_write(2, 1, PK_DIFF_HIGH, 1, 32'sh8000_0000));
        send(measure(2, 1, 32'sh7fff_ffff));           // partial offset, saturated

        // Random part across several thresholds, extremes included.
        set_eps(16'hffff);
        random_phase(70);
        set_eps(16'd1);
        hold_request = 1'b1;                           // fill the block, stall its input
        random_phase(85);
        set_eps(16'($urandom));
        idle_max = 0;                                  // back-to-back stretch
        random_phase(50);
        idle_max = 7;
        set_eps(16'd0);
        random_phase(90);
        set_eps(16'($urandom_range(0, 300)));
        random_phase(35);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tpcs_pkg.sv
rtl/tpcs_div.sv
rtl/two_point_calibration_select_top.sv
rtl/tpcs_chk.sv
verif/tpcs_checker.sv
verif/tb.sv
